@@ rtl/rbd_pkg.sv @@
// shared constants, types and index helpers for the ring buffer deque
package rbd_pkg;

    localparam int DEPTH   = 1024;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int OCNT_W  = 11;

    localparam logic [OP_W-1:0] OP_QUERY      = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } t_state;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [SUM_W-1:0] t_sum;

    // reduce a sum below 2*DEPTH into a ring slot
    function automatic t_idx wrap_idx(input t_sum s);
        t_sum r;
        if (s >= SUM_W'(DEPTH)) begin
            r = s - SUM_W'(DEPTH);
        end else begin
            r = s;
        end
        return r[IDX_W-1:0];
    endfunction

    // step a ring slot back by one
    function automatic t_idx dec_idx(input t_idx i);
        t_idx r;
        if (i == '0) begin
            r = IDX_W'(DEPTH - 1);
        end else begin
            r = i - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

@@ rtl/rbd_ram.sv @@
// single-port synchronous ram with registered read data
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ring_buffer_deque.sv @@
// ring buffer deque top level: pointer control, end-value cache and result register
//
// A double-ended queue of signed 32-bit words in a ring of rbd_pkg::DEPTH slots
// held in a single-port RAM. The front and back words are cached in registers, so
// queries, pushes and pops that leave at most one entry need no RAM read. A pop that
// leaves two or more entries behind passes through the fetch state: the new end word
// is read from the RAM, whose read data is registered. One request is worked on at a
// time, and the next one is accepted as soon as the result register is free or is
// being taken. A push into a full ring is dropped and flagged; a pop of an empty
// ring returns zero with pop_hit low. There is no clearing pass after reset.
module ring_buffer_deque (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rbd_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [rbd_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [rbd_pkg::DATA_W-1:0] o_popped_value,
    output logic                              o_pop_hit,
    output logic                              o_push_refused,
    output logic [rbd_pkg::OCNT_W-1:0]        o_entry_count,
    output logic                              o_is_empty,
    output logic signed [rbd_pkg::DATA_W-1:0] o_front_value,
    output logic signed [rbd_pkg::DATA_W-1:0] o_back_value
);

    rbd_pkg::t_state r_state, n_state;
    rbd_pkg::t_idx   r_front, n_front;
    rbd_pkg::t_cnt   r_count, n_count;
    logic [rbd_pkg::DATA_W-1:0] r_front_val, n_front_val;
    logic [rbd_pkg::DATA_W-1:0] r_back_val, n_back_val;
    logic [rbd_pkg::DATA_W-1:0] r_hold_popped, n_hold_popped;
    logic                       r_hold_fsel, n_hold_fsel;
    logic                       r_out_valid;
    logic [rbd_pkg::DATA_W-1:0] r_o_popped, r_o_front, r_o_back;
    logic                       r_o_hit, r_o_refused, r_o_empty;
    logic [rbd_pkg::OCNT_W-1:0] r_o_count;

    logic                       out_free, accept, load_out;
    logic                       full, empty;
    logic                       mem_en, mem_we;
    rbd_pkg::t_idx              mem_addr;
    logic [rbd_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
    logic [rbd_pkg::DATA_W-1:0] res_popped;
    logic                       res_hit, res_refused;
    logic [rbd_pkg::CNT_W+rbd_pkg::OCNT_W-1:0] cnt_ext;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == rbd_pkg::S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_count       = r_count;
        n_front_val   = r_front_val;
        n_back_val    = r_back_val;
        n_hold_popped = r_hold_popped;
        n_hold_fsel   = r_hold_fsel;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = r_front;
        mem_wdata     = i_push_value;
        res_popped    = '0;
        res_hit       = 1'b0;
        res_refused   = 1'b0;
        load_out      = 1'b0;

        if (r_state == rbd_pkg::S_FETCH) begin
            if (out_free) begin
                if (r_hold_fsel) begin
                    n_front_val = mem_rdata;
                end else begin
                    n_back_val = mem_rdata;
                end
                res_popped = r_hold_popped;
                res_hit    = 1'b1;
                load_out   = 1'b1;
                n_state    = rbd_pkg::S_IDLE;
            end
        end else if (accept) begin
            load_out = 1'b1;
            case (i_opcode)
                rbd_pkg::OP_PUSH_FRONT: begin
                    if (full) begin
                        res_refused = 1'b1;
                    end else begin
                        n_front     = rbd_pkg::dec_idx(r_front);
                        mem_en      = 1'b1;
                        mem_we      = 1'b1;
                        mem_addr    = n_front;
                        n_front_val = i_push_value;
                        if (empty) begin
                            n_back_val = i_push_value;
                        end
                        n_count = r_count + rbd_pkg::CNT_W'(1);
                    end
                end
                rbd_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        res_refused = 1'b1;
                    end else begin
                        mem_en     = 1'b1;
                        mem_we     = 1'b1;
                        mem_addr   = rbd_pkg::wrap_idx(rbd_pkg::SUM_W'(r_front)
                                     + rbd_pkg::SUM_W'(r_count));
                        n_back_val = i_push_value;
                        if (empty) begin
                            n_front_val = i_push_value;
                        end
                        n_count = r_count + rbd_pkg::CNT_W'(1);
                    end
                end
                rbd_pkg::OP_POP_FRONT: begin
                    if (!empty) begin
                        res_hit    = 1'b1;
                        res_popped = r_front_val;
                        n_front    = rbd_pkg::wrap_idx(rbd_pkg::SUM_W'(r_front)
                                     + rbd_pkg::SUM_W'(1));
                        n_count    = r_count - rbd_pkg::CNT_W'(1);
                        if (r_count == rbd_pkg::CNT_W'(2)) begin
                            n_front_val = r_back_val;
                        end else if (r_count > rbd_pkg::CNT_W'(2)) begin
                            mem_en        = 1'b1;
                            mem_addr      = n_front;
                            n_hold_popped = r_front_val;
                            n_hold_fsel   = 1'b1;
                            load_out      = 1'b0;
                            n_state       = rbd_pkg::S_FETCH;
                        end
                    end
                end
                rbd_pkg::OP_POP_BACK: begin
                    if (!empty) begin
                        res_hit    = 1'b1;
                        res_popped = r_back_val;
                        n_count    = r_count - rbd_pkg::CNT_W'(1);
                        if (r_count == rbd_pkg::CNT_W'(2)) begin
                            n_back_val = r_front_val;
                        end else if (r_count > rbd_pkg::CNT_W'(2)) begin
                            mem_en        = 1'b1;
                            mem_addr      = rbd_pkg::wrap_idx(rbd_pkg::SUM_W'(r_front)
                                            + rbd_pkg::SUM_W'(r_count)
                                            - rbd_pkg::SUM_W'(2));
                            n_hold_popped = r_back_val;
                            n_hold_fsel   = 1'b0;
                            load_out      = 1'b0;
                            n_state       = rbd_pkg::S_FETCH;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign cnt_ext = {{rbd_pkg::OCNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbd_pkg::S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_val   <= n_front_val;
        r_back_val    <= n_back_val;
        r_hold_popped <= n_hold_popped;
        r_hold_fsel   <= n_hold_fsel;
        if (load_out) begin
            r_o_popped  <= res_popped;
            r_o_hit     <= res_hit;
            r_o_refused <= res_refused;
            r_o_count   <= cnt_ext[rbd_pkg::OCNT_W-1:0];
            r_o_empty   <= (n_count == '0);
            r_o_front   <= (n_count == '0) ? '0 : n_front_val;
            r_o_back    <= (n_count == '0) ? '0 : n_back_val;
        end
    end

    rbd_ram #(
        .WIDTH (rbd_pkg::DATA_W),
        .DEPTH (rbd_pkg::DEPTH),
        .AW    (rbd_pkg::IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_o_popped;
    assign o_pop_hit      = r_o_hit;
    assign o_push_refused = r_o_refused;
    assign o_entry_count  = r_o_count;
    assign o_is_empty     = r_o_empty;
    assign o_front_value  = r_o_front;
    assign o_back_value   = r_o_back;

endmodule

@@ sim/rbd_checker.sv @@
// checker for the ring buffer deque: watches both channels, predicts each result and compares
`timescale 1ns / 1ps

module rbd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [rbd_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [rbd_pkg::DATA_W-1:0] i_push_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [rbd_pkg::DATA_W-1:0] i_popped_value,
    input  logic                              i_pop_hit,
    input  logic                              i_push_refused,
    input  logic [rbd_pkg::OCNT_W-1:0]        i_entry_count,
    input  logic                              i_is_empty,
    input  logic signed [rbd_pkg::DATA_W-1:0] i_front_value,
    input  logic signed [rbd_pkg::DATA_W-1:0] i_back_value,
    output int                                o_fail_count,
    output int                                o_pending
);
    import rbd_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic                     hit;
        logic                     refused;
        logic [OCNT_W-1:0]        count;
        logic                     empty;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
    } deque_view_t;

    logic signed [DATA_W-1:0] ring_words [DEPTH];
    int                       head_slot = 0;
    int                       held = 0;
    int                       miss_n = 0;
    deque_view_t              expected_views [$];

    function automatic deque_view_t step_deque(input logic [OP_W-1:0] op,
                                               input logic signed [DATA_W-1:0] val);
        deque_view_t v;
        v = '0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (held >= DEPTH) begin
                v.refused = 1'b1;
            end else if (op == OP_PUSH_FRONT) begin
                head_slot = (head_slot + DEPTH - 1) % DEPTH;
                ring_words[head_slot] = val;
                held++;
            end else begin
                ring_words[(head_slot + held) % DEPTH] = val;
                held++;
            end
        end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
            if (held != 0) begin
                v.hit = 1'b1;
                if (op == OP_POP_FRONT) begin
                    v.popped  = ring_words[head_slot];
                    head_slot = (head_slot + 1) % DEPTH;
                end else begin
                    v.popped = ring_words[(head_slot + held - 1) % DEPTH];
                end
                held--;
            end
        end
        v.count = OCNT_W'(held);
        v.empty = (held == 0);
        if (held != 0) begin
            v.front = ring_words[head_slot];
            v.back  = ring_words[(head_slot + held - 1) % DEPTH];
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        deque_view_t want;
        deque_view_t got;
        if (!i_rst_n) begin
            head_slot = 0;
            held      = 0;
            expected_views.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_popped_value, i_pop_hit, i_push_refused, i_entry_count,
                        i_is_empty, i_front_value, i_back_value};
                if (expected_views.size() == 0) begin
                    miss_n++;
                    if (miss_n <= 10) begin
                        $display("%0t: result with no request waiting", $realtime);
                    end
                end else begin
                    want = expected_views[0];
                    expected_views.delete(0);
                    if (got.popped !== want.popped || got.hit !== want.hit ||
                        got.refused !== want.refused || got.count !== want.count ||
                        got.empty !== want.empty || got.front !== want.front ||
                        got.back !== want.back) begin
                        miss_n++;
                        if (miss_n <= 10) begin
                            $display({"%0t: mismatch exp pop=%0d hit=%0b ref=%0b cnt=%0d ",
                                      "emp=%0b front=%0d back=%0d | got pop=%0d hit=%0b ",
                                      "ref=%0b cnt=%0d emp=%0b front=%0d back=%0d"},
                                     $realtime, want.popped, want.hit, want.refused,
                                     want.count, want.empty, want.front, want.back,
                                     got.popped, got.hit, got.refused, got.count,
                                     got.empty, got.front, got.back);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_views = {expected_views, step_deque(i_opcode, i_push_value)};
            end
        end
        o_fail_count <= miss_n;
        o_pending    <= expected_views.size();
    end

endmodule

@@ sim/tb_top.sv @@
// testbench top for the ring buffer deque: request stimulus, random stalls and final verdict
`timescale 1ns / 1ps

module tb_top;
    import rbd_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode = OP_QUERY;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] popped_value;
    logic                     pop_hit;
    logic                     push_refused;
    logic [OCNT_W-1:0]        entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    int                       fail_count;
    int                       pending;

    logic quiet = 1'b0;
    int   level = 0;
    int   sent_n = 0;
    int   gap_pct = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ring_buffer_deque u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_push_value   (push_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_popped_value (popped_value),
        .o_pop_hit      (pop_hit),
        .o_push_refused (push_refused),
        .o_entry_count  (entry_count),
        .o_is_empty     (is_empty),
        .o_front_value  (front_value),
        .o_back_value   (back_value)
    );

    rbd_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_push_value   (push_value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_popped_value (popped_value),
        .i_pop_hit      (pop_hit),
        .i_push_refused (push_refused),
        .i_entry_count  (entry_count),
        .i_is_empty     (is_empty),
        .i_front_value  (front_value),
        .i_back_value   (back_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end
        if (r < push_pct + pop_pct) begin
            return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
        end
        if (r < push_pct + pop_pct + 6) begin
            return OP_SPARE_A + OP_W'($urandom_range(0, 2));
        end
        return OP_QUERY;
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
        int gap;
        if (sent_n % 64 == 0) begin
            gap_pct = ($urandom_range(0, 1) != 0) ? 30 : 0;
        end
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        push_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && level < DEPTH) begin
            level++;
        end else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && level > 0) begin
            level--;
        end
        sent_n++;
    endtask

    // random output stall bursts, none in the quiet tail
    initial begin
        int  n;
        logic v;
        forever begin
            if (quiet) begin
                v = 1'b0;
                n = 1;
            end else if ($urandom_range(0, 2) == 0) begin
                v = 1'b1;
                n = $urandom_range(1, 8);
            end else begin
                v = 1'b0;
                n = $urandom_range(1, 30);
            end
            repeat (n) begin
                @(posedge clk);
                out_stall <= v;
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, spare opcodes, extreme words, wrap of the front slot
        send_req(OP_QUERY, rand_word());
        send_req(OP_POP_FRONT, rand_word());
        send_req(OP_POP_BACK, rand_word());
        send_req(OP_SPARE_A, rand_word());
        send_req(OP_SPARE_B, rand_word());
        send_req(OP_SPARE_C, rand_word());
        send_req(OP_PUSH_FRONT, 32'sh7fff_ffff);
        send_req(OP_PUSH_BACK, 32'sh8000_0000);
        send_req(OP_PUSH_FRONT, '1);
        send_req(OP_PUSH_BACK, '0);
        send_req(OP_QUERY, '1);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_FRONT, '0);
        send_req(OP_PUSH_BACK, 32'sh0000_0001);
        send_req(OP_SPARE_C, '1);
        send_req(OP_POP_FRONT, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_FRONT, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_PUSH_BACK, 32'sh5555_aaaa);
        send_req(OP_QUERY, 32'shaaaa_5555);

        // balanced mix around a short deque
        repeat (100) send_req(pick_op(40, 40), rand_word());

        // fill to capacity, then work at full so pushes get refused
        while (level < DEPTH) send_req(pick_op(96, 2), rand_word());
        repeat (30) send_req(pick_op(60, 20), rand_word());

        // tail with no idling on either side, mostly draining
        quiet <= 1'b1;
        repeat (80) send_req(pick_op(25, 60), rand_word());

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
